// ----- rtl/mrfc_pkg.sv -----
// package for the modbus reply frame checker: constants, types and the crc byte step
// no dependencies
package mrfc_pkg;

  // longest frame that is counted; later bytes are dropped
  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int PLEN_W    = 10;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  EXC_BIT   = 8'h80;
  localparam logic [7:0]  ADDR_RST  = 8'h01;
  localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(5);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_CRC_ERR   = 2'd2
  } status_t;

  // one frame byte as held in the input register
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } item_t;

  // one verdict
  typedef struct packed {
    status_t           frame_status;
    logic [PLEN_W-1:0] payload_length;
  } result_t;

  // fold one byte into the reflected crc-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrfc_in_stage.sv -----
// input register of the frame checker: one byte transaction held until the evaluator takes it
// depends on mrfc_pkg
module mrfc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] rx_byte
  input  logic           in_tlast,   // last byte of the frame
  output logic           item_vld,
  output mrfc_pkg::item_t item,
  input  logic           item_rdy
);

  logic            vld_r, vld_nxt;
  mrfc_pkg::item_t item_r;
  logic            load;

  // take a new byte when empty or when the held one moves on
  assign in_tready = !vld_r || item_rdy;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && item_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.rx_byte <= in_tdata;
      item_r.last    <= in_tlast;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ----- rtl/mrfc_frame_eval.sv -----
// frame state (crc, held checksum bytes, count, flags) and the result register
// depends on mrfc_pkg
module mrfc_frame_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           expected_addr,
  input  logic                 item_vld,
  input  mrfc_pkg::item_t      item,
  output logic                 item_rdy,
  output logic                 res_vld,
  output mrfc_pkg::result_t    res,
  input  logic                 res_rdy
);

  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 held0_r, held0_nxt;
  logic [7:0]                 held1_r, held1_nxt;
  logic [mrfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       addr_bad_r, addr_bad_nxt;
  logic                       exc_r, exc_nxt;
  logic                       res_vld_r, res_vld_nxt;
  mrfc_pkg::result_t          res_r, res_nxt;
  logic                       out_free;
  logic                       take;
  logic [15:0]                rx_crc;
  logic [mrfc_pkg::CNT_W-1:0] plen_full;

  // a middle byte never waits; a last byte needs a free result register
  assign out_free = !res_vld_r || res_rdy;
  assign item_rdy = !item.last || out_free;
  assign take     = item_vld && item_rdy;

  always_comb begin
    crc_nxt      = crc_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    cnt_nxt      = cnt_r;
    addr_bad_nxt = addr_bad_r;
    exc_nxt      = exc_r;
    res_vld_nxt  = res_vld_r && !res_rdy;
    res_nxt      = res_r;
    rx_crc       = 16'h0000;
    plen_full    = '0;
    if (take) begin
      // bytes past the buffer size are dropped
      if (cnt_r < mrfc_pkg::CNT_W'(mrfc_pkg::MAX_FRAME)) begin
        if (cnt_r == '0 && item.rx_byte != expected_addr) begin
          addr_bad_nxt = 1'b1;
        end
        if (cnt_r == mrfc_pkg::CNT_W'(1) && (item.rx_byte & mrfc_pkg::EXC_BIT) != 8'h00) begin
          exc_nxt = 1'b1;
        end
        if (cnt_r >= mrfc_pkg::CNT_W'(2)) begin
          crc_nxt = mrfc_pkg::crc_fold(crc_r, held0_r);
        end
        held0_nxt = held1_r;
        held1_nxt = item.rx_byte;
        cnt_nxt   = cnt_r + mrfc_pkg::CNT_W'(1);
      end
      // verdict on the final byte, then back to reset state
      if (item.last) begin
        rx_crc    = {held1_nxt, held0_nxt};
        plen_full = cnt_nxt - mrfc_pkg::MIN_FRAME;
        res_vld_nxt = 1'b1;
        res_nxt.payload_length = '0;
        if (cnt_nxt < mrfc_pkg::MIN_FRAME || addr_bad_nxt || exc_nxt) begin
          res_nxt.frame_status = mrfc_pkg::ST_MALFORMED;
        end else if (rx_crc != crc_nxt) begin
          res_nxt.frame_status = mrfc_pkg::ST_CRC_ERR;
        end else begin
          res_nxt.frame_status   = mrfc_pkg::ST_OK;
          res_nxt.payload_length = mrfc_pkg::PLEN_W'(plen_full);
        end
        crc_nxt      = mrfc_pkg::CRC_INIT;
        held0_nxt    = 8'h00;
        held1_nxt    = 8'h00;
        cnt_nxt      = '0;
        addr_bad_nxt = 1'b0;
        exc_nxt      = 1'b0;
      end
    end
  end

  // frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= mrfc_pkg::CRC_INIT;
      held0_r    <= 8'h00;
      held1_r    <= 8'h00;
      cnt_r      <= '0;
      addr_bad_r <= 1'b0;
      exc_r      <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      cnt_r      <= cnt_nxt;
      addr_bad_r <= addr_bad_nxt;
      exc_r      <= exc_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ----- rtl/modbus_reply_frame_check.sv -----
// top level of the modbus rtu reply frame checker
// depends on mrfc_pkg, mrfc_in_stage and mrfc_frame_eval
//
// Usage:
//   in_*  : one received frame byte per transaction, in_tlast on the final byte.
//   out_* : one verdict per frame, issued for the final byte only.
//   cfg_* : writes the expected slave address (reset value 1); always ready;
//           the user must write it only while no frame is in flight (not enforced).
// Flow: the final byte's transaction loads the input register, then the
//   verdict is loaded into the result register and shows on out_tvalid.
// Throughput: one byte per cycle unless a final byte waits on a pending verdict; the byte-wide crc
//   step and the checks are combinational between the input register and the result register.
// Reset (rst_n low, synchronous): crc back to 0xFFFF, count and flags
//   cleared, no verdict pending, address register back to 1.
// Stall: while a verdict waits on out_tready, middle bytes of the next frame
//   are still taken; a final byte waits in the input register until the
//   verdict is taken.
module modbus_reply_frame_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // final byte of the frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] frame_status, [11:2] payload_length, [15:12] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic              item_vld;
  mrfc_pkg::item_t   item;
  logic              item_rdy;
  logic              res_vld;
  mrfc_pkg::result_t res;
  logic [7:0]        addr_r, addr_nxt;

  // expected address register
  assign cfg_ready = 1'b1;
  assign addr_nxt  = (cfg_valid && cfg_ready) ? cfg_data : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= mrfc_pkg::ADDR_RST;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  mrfc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .item_vld  (item_vld),
    .item      (item),
    .item_rdy  (item_rdy)
  );

  mrfc_frame_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .expected_addr (addr_r),
    .item_vld      (item_vld),
    .item          (item),
    .item_rdy      (item_rdy),
    .res_vld       (res_vld),
    .res           (res),
    .res_rdy       (out_tready)
  );

  // pack the verdict
  assign out_tvalid = res_vld;
  assign out_tdata  = {4'h0, res.payload_length, res.frame_status};

endmodule

// ----- rtl/mrfc_checker.sv -----
// port-level checks for the modbus reply frame checker, bound to the top level
// depends on modbus_reply_frame_check
module mrfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // no verdict right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("verdict valid after reset");

  // only the three status codes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status code");

  // a failed frame reports no payload, padding stays zero
  a_plen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[15:2] == 14'd0)
    else $error("payload length on a failed frame");

endmodule

bind modbus_reply_frame_check mrfc_checker u_mrfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
